// ===== rtl/grid_fov_ray_cast_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the grid field-of-view ray caster
// Implication checks that vanish when the design is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef GRID_FOV_RAY_CAST_DEFINES_SVH
`define GRID_FOV_RAY_CAST_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define GFRC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gfrc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GFRC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gfrc assertion failed");
`else
`define GFRC_ASSERT_IMP(name, clk, rstn, ante, cons)
`define GFRC_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/gfrc_pkg.sv =====
// ---------------------------------------------------------------------------
// gfrc_pkg
// Command codes, register indexes and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none

package gfrc_pkg;

  localparam int CmdW     = 3;
  localparam int PosW     = 6;
  localparam int RadW     = 7;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_WR_TRANS = 3'd0,
    CMD_COMPUTE  = 3'd1,
    CMD_QUERY    = 3'd2,
    CMD_CLEAR    = 3'd3,
    CMD_WR_EXPL  = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sweep_clr;
    logic sweep_en;
    logic sweep_all;
    logic sweep_exp;
    logic wr_cmd;
    logic rd_pos;
    logic mark_origin;
    logic tgt_init;
    logic tgt_next;
    logic ray_init;
    logic ray_mark;
    logic ray_step;
    logic res_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            ok;
    logic            sweep_last;
    logic            r_zero;
    logic            tgt_in_disc;
    logic            tgt_last;
    logic            ray_ok;
    logic            ray_stop;
    logic            out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/grid_fov_ray_cast.sv =====
// ---------------------------------------------------------------------------
// grid_fov_ray_cast
// Field of view on a tile grid by Bresenham ray casting, with explored map.
// ---------------------------------------------------------------------------
// The block keeps three one-bit maps of MAX_WIDTH x MAX_HEIGHT cells
// (transparency, visible, explored) in block RAM and takes one command word
// at a time, returning exactly one result word for each. After reset a
// clearing pass zeroes all three maps, during which no command word is
// taken; grid size writes are accepted at any time. A tile write,
// explored-bit write or query passes through a dispatch state and a done
// state before its result is held in the output register; the done state
// waits while an earlier result is still stalled there. A clear sweeps the
// visible and explored RAMs one cell per cycle. A compute sweeps the visible
// RAM alone and marks the origin, then visits every cell of the bounding
// box of the view disc and casts a ray to each one inside it; each ray step
// writes the visible and explored bits and then waits for the registered
// transparency read. Cell (x, y) lives at y * MAX_WIDTH + x whatever the
// grid size registers hold, so resizing the grid keeps every cell's bits. A
// new command word may be taken while the previous result still waits to be
// collected.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_fov_ray_cast import gfrc_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Grid size register writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Command words.
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CmdW-1:0]     cmd_i,
  input  wire logic [PosW-1:0]     pos_x_i,
  input  wire logic [PosW-1:0]     pos_y_i,
  input  wire logic [RadW-1:0]     radius_i,
  input  wire logic                bit_value_i,
  // Result words.
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     visible_o,
  output logic                     explored_o,
  output logic                     status_o
);

  ctl_t ctl;
  sts_t sts;

  // Register writes are taken whenever they are valid, so the port never holds off.
  assign cfg_ready_o = 1'b1;

  gfrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  gfrc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .radius_i    (radius_i),
    .bit_value_i (bit_value_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .visible_o   (visible_o),
    .explored_o  (explored_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

// ===== rtl/gfrc_ram.sv =====
// ---------------------------------------------------------------------------
// gfrc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module gfrc_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/gfrc_datapath.sv =====
// ---------------------------------------------------------------------------
// gfrc_datapath
// Grid registers, the three bitmaps, target scan, Bresenham stepper, result.
// ---------------------------------------------------------------------------
`default_nettype none

module gfrc_datapath import gfrc_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [CmdW-1:0]     cmd_i,
  input  wire logic [PosW-1:0]     pos_x_i,
  input  wire logic [PosW-1:0]     pos_y_i,
  input  wire logic [RadW-1:0]     radius_i,
  input  wire logic                bit_value_i,
  input  wire ctl_t                ctl_i,
  output sts_t                     sts_o,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic                     visible_o,
  output logic                     explored_o,
  output logic                     status_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CW0   = (XW > YW) ? XW : YW;
  localparam int CW    = (CW0 > PosW) ? CW0 : PosW;
  localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Cells);
  localparam int SW    = ((CW > RadW) ? CW : RadW) + 1;
  localparam int DW    = 2 * CW + 1;
  localparam int R2W   = 2 * RadW;
  localparam int QW    = (DW > R2W) ? DW : R2W;
  localparam int EW    = CW + 3;

  // Grid size registers and their clamped values.
  logic [CfgDataW-1:0] cfg_w_q, cfg_h_q;
  logic [CW:0]         eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 7'd64;
      cfg_h_q <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:  cfg_w_q <= cfg_data_i;
        CFG_GRID_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_q == '0) begin
      eff_w = (CW+1)'(1);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      eff_h = (CW+1)'(1);
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      eff_h = (CW+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (CW+1)'(cfg_h_q);
    end
  end

  // Latched command word.
  logic [CmdW-1:0] cmd_q;
  logic [CW-1:0]   ox_q, oy_q;
  logic [RadW-1:0] rad_q;
  logic [R2W-1:0]  r2_q;
  logic            bit_q, ok_q;
  logic            pos_in;

  assign pos_in = ({1'b0, CW'(pos_x_i)} < eff_w) && ({1'b0, CW'(pos_y_i)} < eff_h);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      ox_q  <= CW'(pos_x_i);
      oy_q  <= CW'(pos_y_i);
      rad_q <= radius_i;
      r2_q  <= R2W'(radius_i) * R2W'(radius_i);
      bit_q <= bit_value_i;
      ok_q  <= pos_in;
    end
  end

  // Target scan over the bounding box of the disc.
  logic [CW-1:0] tx_q, ty_q, x0_q, x1_q, y1_q;
  logic [SW-1:0] ox_s, oy_s, r_s, xsum, ysum, wmax, hmax;
  logic [CW-1:0] x0_d, x1_d, y0_d, y1_d;

  always_comb begin
    ox_s = SW'(ox_q);
    oy_s = SW'(oy_q);
    r_s  = SW'(rad_q);
    xsum = ox_s + r_s;
    ysum = oy_s + r_s;
    wmax = SW'(eff_w) - SW'(1);
    hmax = SW'(eff_h) - SW'(1);
    x0_d = (ox_s >= r_s) ? CW'(ox_s - r_s) : '0;
    y0_d = (oy_s >= r_s) ? CW'(oy_s - r_s) : '0;
    x1_d = (xsum > wmax) ? CW'(wmax) : CW'(xsum);
    y1_d = (ysum > hmax) ? CW'(hmax) : CW'(ysum);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tgt_init) begin
      x0_q <= x0_d;
      x1_q <= x1_d;
      y1_q <= y1_d;
      tx_q <= x0_d;
      ty_q <= y0_d;
    end else if (ctl_i.tgt_next) begin
      if (tx_q == x1_q) begin
        tx_q <= x0_q;
        ty_q <= ty_q + 1'b1;
      end else begin
        tx_q <= tx_q + 1'b1;
      end
    end
  end

  // Distances from the origin to the target and to the ray's cell.
  logic [CW-1:0] cx_q, cy_q, rdx_q, rdy_q;
  logic          sx_q, sy_q;
  logic signed [EW-1:0] err_q;
  logic [CW-1:0] tdx, tdy, cdx, cdy;
  logic [DW-1:0] tdist, cdist;
  logic          cur_in;

  always_comb begin
    tdx    = (tx_q >= ox_q) ? tx_q - ox_q : ox_q - tx_q;
    tdy    = (ty_q >= oy_q) ? ty_q - oy_q : oy_q - ty_q;
    cdx    = (cx_q >= ox_q) ? cx_q - ox_q : ox_q - cx_q;
    cdy    = (cy_q >= oy_q) ? cy_q - oy_q : oy_q - cy_q;
    tdist  = DW'(tdx) * DW'(tdx) + DW'(tdy) * DW'(tdy);
    cdist  = DW'(cdx) * DW'(cdx) + DW'(cdy) * DW'(cdy);
    cur_in = ({1'b0, cx_q} < eff_w) && ({1'b0, cy_q} < eff_h);
  end

  // Bresenham stepper.
  logic signed [EW:0]   twice, ndy, pdx;
  logic                 step_x, step_y;
  logic signed [EW-1:0] err_d;

  always_comb begin
    twice  = {err_q, 1'b0};
    ndy    = -$signed((EW+1)'(rdy_q));
    pdx    = $signed((EW+1)'(rdx_q));
    step_x = twice > ndy;
    step_y = twice < pdx;
    err_d  = err_q;
    if (step_x) begin
      err_d = err_d - $signed(EW'(rdy_q));
    end
    if (step_y) begin
      err_d = err_d + $signed(EW'(rdx_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ray_init) begin
      cx_q  <= ox_q;
      cy_q  <= oy_q;
      rdx_q <= tdx;
      rdy_q <= tdy;
      sx_q  <= ox_q < tx_q;
      sy_q  <= oy_q < ty_q;
      err_q <= $signed(EW'(tdx)) - $signed(EW'(tdy));
    end else if (ctl_i.ray_step) begin
      err_q <= err_d;
      if (step_x) begin
        cx_q <= sx_q ? cx_q + 1'b1 : cx_q - 1'b1;
      end
      if (step_y) begin
        cy_q <= sy_q ? cy_q + 1'b1 : cy_q - 1'b1;
      end
    end
  end

  // Clearing sweep counter.
  logic [AW-1:0] sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (ctl_i.sweep_clr) begin
      sweep_q <= '0;
    end else if (ctl_i.sweep_en) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  // Bitmaps.
  logic [AW-1:0] pos_addr, cur_addr;
  logic          vis_we, exp_we, tr_we;
  logic [AW-1:0] vis_waddr, exp_waddr, tr_waddr;
  logic          vis_wdata, exp_wdata, tr_wdata;
  logic          vis_rd, exp_rd, tr_rd;

  assign pos_addr = AW'(32'(oy_q) * MAX_WIDTH + 32'(ox_q));
  assign cur_addr = AW'(32'(cy_q) * MAX_WIDTH + 32'(cx_q));

  always_comb begin
    vis_we    = ctl_i.sweep_en | ctl_i.mark_origin | ctl_i.ray_mark;
    vis_waddr = ctl_i.sweep_en ? sweep_q : (ctl_i.mark_origin ? pos_addr : cur_addr);
    vis_wdata = !ctl_i.sweep_en;

    exp_we = (ctl_i.sweep_en & ctl_i.sweep_exp) | ctl_i.mark_origin | ctl_i.ray_mark
           | (ctl_i.wr_cmd & (cmd_q == CMD_WR_EXPL) & ok_q);
    if (ctl_i.sweep_en) begin
      exp_waddr = sweep_q;
      exp_wdata = 1'b0;
    end else if (ctl_i.wr_cmd) begin
      exp_waddr = pos_addr;
      exp_wdata = bit_q;
    end else begin
      exp_waddr = ctl_i.mark_origin ? pos_addr : cur_addr;
      exp_wdata = 1'b1;
    end

    tr_we    = (ctl_i.sweep_en & ctl_i.sweep_all)
             | (ctl_i.wr_cmd & (cmd_q == CMD_WR_TRANS) & ok_q);
    tr_waddr = ctl_i.sweep_en ? sweep_q : pos_addr;
    tr_wdata = ctl_i.sweep_en ? 1'b0 : bit_q;
  end

  gfrc_ram #(.Width(1), .Depth(Cells)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (ctl_i.rd_pos),
    .raddr_i (pos_addr),
    .rdata_o (vis_rd)
  );

  gfrc_ram #(.Width(1), .Depth(Cells)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (exp_wdata),
    .re_i    (ctl_i.rd_pos),
    .raddr_i (pos_addr),
    .rdata_o (exp_rd)
  );

  gfrc_ram #(.Width(1), .Depth(Cells)) u_tr_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .re_i    (ctl_i.ray_mark),
    .raddr_i (cur_addr),
    .rdata_o (tr_rd)
  );

  // Result register.
  logic out_valid_q, vis_q, exp_q, st_q;
  logic is_query, has_pos;

  assign is_query = (cmd_q == CMD_QUERY) && ok_q;
  assign has_pos  = (cmd_q == CMD_WR_TRANS) || (cmd_q == CMD_COMPUTE)
                 || (cmd_q == CMD_QUERY) || (cmd_q == CMD_WR_EXPL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      vis_q <= is_query ? vis_rd : 1'b0;
      exp_q <= is_query ? exp_rd : 1'b0;
      st_q  <= has_pos && !ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = vis_q;
  assign explored_o  = exp_q;
  assign status_o    = st_q;

  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.ok          = ok_q;
    sts_o.sweep_last  = sweep_q == AW'(Cells - 1);
    sts_o.r_zero      = rad_q == '0;
    sts_o.tgt_in_disc = QW'(tdist) <= QW'(r2_q);
    sts_o.tgt_last    = (tx_q == x1_q) && (ty_q == y1_q);
    sts_o.ray_ok      = cur_in && (QW'(cdist) <= QW'(r2_q));
    sts_o.ray_stop    = !tr_rd || ((cx_q == tx_q) && (cy_q == ty_q));
    sts_o.out_busy    = out_valid_q && out_stall_i;
  end

endmodule

`default_nettype wire

// ===== rtl/gfrc_ctrl.sv =====
// ---------------------------------------------------------------------------
// gfrc_ctrl
// Sequencer for clearing sweeps, the target scan and the ray stepper.
// ---------------------------------------------------------------------------
`default_nettype none

`include "grid_fov_ray_cast_defines.svh"

module gfrc_ctrl import gfrc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  typedef enum logic [9:0] {
    S_BOOT     = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_DISPATCH = 10'b0000000100,
    S_SWEEP    = 10'b0000001000,
    S_ORIGIN   = 10'b0000010000,
    S_TGT      = 10'b0000100000,
    S_TNEXT    = 10'b0001000000,
    S_CHECK    = 10'b0010000000,
    S_READ     = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_BOOT: begin
        ctl_o.sweep_en  = 1'b1;
        ctl_o.sweep_all = 1'b1;
        ctl_o.sweep_exp = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          CMD_WR_TRANS, CMD_WR_EXPL: begin
            ctl_o.wr_cmd = 1'b1;
            state_d      = S_DONE;
          end
          CMD_COMPUTE, CMD_CLEAR: begin
            ctl_o.sweep_clr = 1'b1;
            state_d         = S_SWEEP;
          end
          CMD_QUERY: begin
            ctl_o.rd_pos = 1'b1;
            state_d      = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SWEEP: begin
        ctl_o.sweep_en  = 1'b1;
        ctl_o.sweep_exp = (sts_i.cmd == CMD_CLEAR);
        if (sts_i.sweep_last) begin
          state_d = ((sts_i.cmd == CMD_COMPUTE) && sts_i.ok) ? S_ORIGIN : S_DONE;
        end
      end
      S_ORIGIN: begin
        ctl_o.mark_origin = 1'b1;
        if (sts_i.r_zero) begin
          state_d = S_DONE;
        end else begin
          ctl_o.tgt_init = 1'b1;
          state_d        = S_TGT;
        end
      end
      S_TGT: begin
        if (sts_i.tgt_in_disc) begin
          ctl_o.ray_init = 1'b1;
          state_d        = S_CHECK;
        end else begin
          state_d = S_TNEXT;
        end
      end
      S_TNEXT: begin
        if (sts_i.tgt_last) begin
          state_d = S_DONE;
        end else begin
          ctl_o.tgt_next = 1'b1;
          state_d        = S_TGT;
        end
      end
      S_CHECK: begin
        if (sts_i.ray_ok) begin
          ctl_o.ray_mark = 1'b1;
          state_d        = S_READ;
        end else begin
          state_d = S_TNEXT;
        end
      end
      S_READ: begin
        if (sts_i.ray_stop) begin
          state_d = S_TNEXT;
        end else begin
          ctl_o.ray_step = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          ctl_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A result that cannot be handed over keeps the sequencer waiting.
  `GFRC_ASSERT_NXT(a_done_holds, clk_i, rst_ni, (state_q == S_DONE) && sts_i.out_busy, state_q == S_DONE)
  // A cell that passed its checks is always followed by the transparency test.
  `GFRC_ASSERT_NXT(a_mark_then_read, clk_i, rst_ni, (state_q == S_CHECK) && sts_i.ray_ok, state_q == S_READ)
  // An accepted word is always decoded in the following cycle.
  `GFRC_ASSERT_NXT(a_accept_dispatch, clk_i, rst_ni, (state_q == S_IDLE) && in_valid_i, state_q == S_DISPATCH)

endmodule

`default_nettype wire

// ===== bench/grid_fov_ray_cast_tb.sv =====
// ---------------------------------------------------------------------------
// Grid field-of-view ray caster testbench
// Drives command words, grid size writes and random idling into the block,
// predicts every result word from a model of the three maps and checks the
// words in order through a small scoreboard.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_fov_ray_cast_tb;
  import gfrc_pkg::*;

  localparam int MaxW  = 64;
  localparam int MaxH  = 64;
  localparam int Cells = MaxW * MaxH;

  // One predicted or observed result word.
  typedef struct packed {
    logic visible;
    logic explored;
    logic status;
  } view_res_t;

  // Map model and the queue of predicted result words.
  class view_scoreboard;
    bit             trans_map[Cells];
    bit             vis_map[Cells];
    bit             expl_map[Cells];
    logic [6:0]     width_reg;
    logic [6:0]     height_reg;
    view_res_t      pending[$];
    int unsigned    errors;
    int unsigned    checked;

    function void reset_maps();
      for (int i = 0; i < Cells; i++) begin
        trans_map[i] = 1'b0;
        vis_map[i]   = 1'b0;
        expl_map[i]  = 1'b0;
      end
      width_reg  = 7'd64;
      height_reg = 7'd64;
      pending.delete();
      errors  = 0;
      checked = 0;
    endfunction

    function int used_w();
      if (width_reg == 0) return 1;
      if (width_reg > MaxW) return MaxW;
      return int'(width_reg);
    endfunction

    function int used_h();
      if (height_reg == 0) return 1;
      if (height_reg > MaxH) return MaxH;
      return int'(height_reg);
    endfunction

    function bit on_grid(int x, int y);
      return x >= 0 && x < used_w() && y >= 0 && y < used_h();
    endfunction

    function void see(int x, int y);
      vis_map[y * MaxW + x]  = 1'b1;
      expl_map[y * MaxW + x] = 1'b1;
    endfunction

    // Walk one Bresenham line from the origin towards the target cell.
    function void cast_line(int ox, int oy, int tx, int ty, int r2);
      int dx, dy, sx, sy, err, cx, cy, e2;
      dx  = tx > ox ? tx - ox : ox - tx;
      dy  = ty > oy ? ty - oy : oy - ty;
      sx  = ox < tx ? 1 : -1;
      sy  = oy < ty ? 1 : -1;
      err = dx - dy;
      cx  = ox;
      cy  = oy;
      forever begin
        if (!on_grid(cx, cy)) break;
        if ((cx - ox) * (cx - ox) + (cy - oy) * (cy - oy) > r2) break;
        see(cx, cy);
        if (!trans_map[cy * MaxW + cx]) break;
        if (cx == tx && cy == ty) break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          cx  += sx;
        end
        if (e2 < dx) begin
          err += dx;
          cy  += sy;
        end
      end
    endfunction

    function void compute_fov(int ox, int oy, int r);
      int x0, x1, y0, y1;
      see(ox, oy);
      if (r == 0) return;
      x0 = ox - r < 0 ? 0 : ox - r;
      x1 = ox + r > used_w() - 1 ? used_w() - 1 : ox + r;
      y0 = oy - r < 0 ? 0 : oy - r;
      y1 = oy + r > used_h() - 1 ? used_h() - 1 : oy + r;
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++)
          if ((x - ox) * (x - ox) + (y - oy) * (y - oy) <= r * r)
            cast_line(ox, oy, x, y, r * r);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [6:0] val);
      if (idx == CFG_GRID_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    // Note an accepted command word and queue the result it must produce.
    function void note_command(logic [2:0] cmd, int x, int y, int r, bit b);
      view_res_t res;
      bit        ok;
      ok  = on_grid(x, y);
      res = '0;
      case (cmd)
        CMD_WR_TRANS: begin
          if (ok) trans_map[y * MaxW + x] = b;
          else res.status = 1'b1;
        end
        CMD_COMPUTE: begin
          for (int i = 0; i < Cells; i++) vis_map[i] = 1'b0;
          if (ok) compute_fov(x, y, r);
          else res.status = 1'b1;
        end
        CMD_QUERY: begin
          if (ok) begin
            res.visible  = vis_map[y * MaxW + x];
            res.explored = expl_map[y * MaxW + x];
          end else begin
            res.status = 1'b1;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < Cells; i++) begin
            vis_map[i]  = 1'b0;
            expl_map[i] = 1'b0;
          end
        end
        CMD_WR_EXPL: begin
          if (ok) expl_map[y * MaxW + x] = b;
          else res.status = 1'b1;
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    // Compare one collected result word with the oldest prediction.
    task check_result(view_res_t got);
      view_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing predicted", 0, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.visible !== want.visible)
        report_mismatch("visible", int'(got.visible), int'(want.visible));
      if (got.explored !== want.explored)
        report_mismatch("explored", int'(got.explored), int'(want.explored));
      if (got.status !== want.status)
        report_mismatch("status", int'(got.status), int'(want.status));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [CmdW-1:0]     cmd;
  logic [PosW-1:0]     pos_x;
  logic [PosW-1:0]     pos_y;
  logic [RadW-1:0]     radius;
  logic                bit_value;
  logic                out_valid;
  logic                out_stall;
  logic                visible;
  logic                explored;
  logic                status;

  view_scoreboard fov_sb;
  int unsigned    mismatch_count;
  // Once set, neither side inserts idle cycles any more.
  bit             steady_phase;
  int unsigned    computes_done;

  grid_fov_ray_cast dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .radius_i    (radius),
    .bit_value_i (bit_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .visible_o   (visible),
    .explored_o  (explored),
    .status_o    (status)
  );

  // Every mismatch passes through here: one line, one count.
  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one command word and hold it until the block takes it. The
  // prediction is made at the accepting edge so that the map model follows
  // the order in which the block sees the words. Valid stays high after the
  // edge so that the next word can follow at once; an idle gap or a drain
  // takes it low.
  task automatic send_command(logic [2:0] c, logic [5:0] x, logic [5:0] y,
                              logic [6:0] r, logic b);
    int gap;
    if (!steady_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= c;
    pos_x     <= x;
    pos_y     <= y;
    radius    <= r;
    bit_value <= b;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    fov_sb.note_command(c, int'(x), int'(y), int'(r), b);
    if (c == CMD_COMPUTE) computes_done++;
  endtask

  // Write a grid size register. Only called once the block has gone quiet.
  task automatic write_size(cfg_idx_e idx, logic [6:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    fov_sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted word has come back, then let the block idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (fov_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // The receiving side: random stall bursts, and a check at every edge at
  // which a result word is taken.
  initial begin
    int burst;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        fov_sb.check_result('{visible: visible, explored: explored, status: status});
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall <= 1'b0;
      end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall <= 1'b1;
      end
    end
  end

  // Pick a cell: mostly inside the grid, now and then anywhere.
  function automatic logic [5:0] pick_coord(int lim);
    if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, lim - 1));
  endfunction

  // One random word: mostly map building and queries, with the odd small
  // compute. Larger radii are rare since a compute is slow.
  task automatic random_command();
    logic [2:0] c;
    logic [6:0] r;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      c = CMD_WR_TRANS;
    else if (pick < 48) c = CMD_COMPUTE;
    else if (pick < 80) c = CMD_QUERY;
    else if (pick < 83) c = CMD_CLEAR;
    else if (pick < 95) c = CMD_WR_EXPL;
    else                c = 3'($urandom_range(5, 7));
    r = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                    : 7'($urandom_range(0, 8));
    // Compute words are limited in number to keep the run short.
    if (c == CMD_COMPUTE && computes_done > 14) c = CMD_QUERY;
    send_command(c, pick_coord(fov_sb.used_w()), pick_coord(fov_sb.used_h()),
                 r, 1'($urandom_range(0, 3) != 0));
  endtask

  initial begin
    fov_sb = new();
    fov_sb.reset_maps();
    mismatch_count = 0;
    steady_phase   = 0;
    computes_done  = 0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cmd       <= CMD_QUERY;
    pos_x     <= '0;
    pos_y     <= '0;
    radius    <= '0;
    bit_value <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the full 64 x 64 grid: open a corridor with a wall,
    // look along it, then probe the corners and the odd cases.
    for (int x = 30; x < 36; x++) send_command(CMD_WR_TRANS, 6'(x), 6'd10, 7'd0, 1'b1);
    send_command(CMD_WR_TRANS, 6'd36, 6'd10, 7'd0, 1'b0);
    send_command(CMD_COMPUTE, 6'd30, 6'd10, 7'd10, 1'b0);
    send_command(CMD_QUERY, 6'd36, 6'd10, 7'd0, 1'b0);   // the wall itself is seen
    send_command(CMD_QUERY, 6'd37, 6'd10, 7'd0, 1'b0);   // hidden behind the wall
    send_command(CMD_QUERY, 6'd63, 6'd63, 7'd0, 1'b0);
    send_command(CMD_WR_EXPL, 6'd63, 6'd63, 7'd0, 1'b1);
    send_command(CMD_QUERY, 6'd63, 6'd63, 7'd0, 1'b0);
    send_command(CMD_WR_EXPL, 6'd31, 6'd10, 7'd0, 1'b0);
    send_command(CMD_QUERY, 6'd31, 6'd10, 7'd0, 1'b0);
    send_command(CMD_COMPUTE, 6'd0, 6'd0, 7'd0, 1'b0); // radius zero: origin only
    send_command(CMD_QUERY, 6'd30, 6'd10, 7'd0, 1'b0);   // visible cleared, explored kept
    send_command(CMD_QUERY, 6'd0, 6'd0, 7'd0, 1'b0);
    send_command(CMD_CLEAR, 6'd0, 6'd0, 7'd0, 1'b0);
    send_command(CMD_QUERY, 6'd0, 6'd0, 7'd0, 1'b0);
    send_command(3'd7, 6'd63, 6'd63, 7'd127, 1'b1);    // unknown command
    send_command(3'd5, 6'd0, 6'd0, 7'd0, 1'b0);
    drain();

    // Shrink the grid to one cell, so that almost everything lies outside.
    write_size(CFG_GRID_WIDTH, 7'd0);
    write_size(CFG_GRID_HEIGHT, 7'd0);
    send_command(CMD_WR_TRANS, 6'd1, 6'd0, 7'd0, 1'b1);
    send_command(CMD_COMPUTE, 6'd5, 6'd5, 7'd3, 1'b0);
    send_command(CMD_COMPUTE, 6'd0, 6'd0, 7'd127, 1'b0);
    send_command(CMD_QUERY, 6'd0, 6'd0, 7'd0, 1'b0);
    send_command(CMD_WR_EXPL, 6'd0, 6'd1, 7'd0, 1'b1);
    drain();

    // Random phases, each on its own grid size; the maximum values above
    // the limit count as the limit and the last phase runs without idling.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_size(CFG_GRID_WIDTH, 7'd127);
          write_size(CFG_GRID_HEIGHT, 7'd12);
        end
        1: begin
          write_size(CFG_GRID_WIDTH, 7'd1);
          write_size(CFG_GRID_HEIGHT, 7'd64);
        end
        2: begin
          write_size(CFG_GRID_WIDTH, 7'($urandom_range(2, 20)));
          write_size(CFG_GRID_HEIGHT, 7'($urandom_range(2, 20)));
        end
        3: begin
          write_size(CFG_GRID_WIDTH, 7'd16);
          write_size(CFG_GRID_HEIGHT, 7'd65);
        end
        default: begin
          write_size(CFG_GRID_WIDTH, 7'd64);
          write_size(CFG_GRID_HEIGHT, 7'd64);
          steady_phase = 1;
        end
      endcase
      repeat (20) random_command();
      drain();
    end

    $display("Covered all five commands, unknown codes, off-grid cells and %0d view",
             computes_done);
    $display("computations over seven grid sizes; %0d result words checked.",
             fov_sb.checked);
    if (mismatch_count == 0 && fov_sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Fifteen computes at most, plus clears, stay far below this timeout.
  initial begin
    #400_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
